// ===== src/sct_pkg.sv =====
`default_nettype none

package sct_pkg;

  // default counter width for line and column positions
  localparam int unsigned PosBitsDefault = 16;

  // lexeme storage depth; the reported length saturates below it
  localparam int unsigned LexemeBuffer = 64;
  localparam int unsigned LenCap = ((LexemeBuffer - 1) < 63) ? (LexemeBuffer - 1) : 63;

  // token kinds
  localparam logic [2:0] TOK_IDENT   = 3'd0;
  localparam logic [2:0] TOK_KEYWORD = 3'd1;
  localparam logic [2:0] TOK_NUMBER  = 3'd2;
  localparam logic [2:0] TOK_OP      = 3'd3;
  localparam logic [2:0] TOK_LPAREN  = 3'd4;
  localparam logic [2:0] TOK_RPAREN  = 3'd5;
  localparam logic [2:0] TOK_EOF     = 3'd6;
  localparam logic [2:0] TOK_ERROR   = 3'd7;

  // run kinds
  localparam logic [1:0] RUN_NONE = 2'd0;
  localparam logic [1:0] RUN_WORD = 2'd1;
  localparam logic [1:0] RUN_NUM  = 2'd2;

  // keyword match progress
  localparam logic [3:0] KW_START = 4'd0;
  localparam logic [3:0] KW_I     = 4'd1;
  localparam logic [3:0] KW_IF    = 4'd2;
  localparam logic [3:0] KW_W     = 4'd3;
  localparam logic [3:0] KW_WH    = 4'd4;
  localparam logic [3:0] KW_WHI   = 4'd5;
  localparam logic [3:0] KW_WHIL  = 4'd6;
  localparam logic [3:0] KW_WHILE = 4'd7;
  localparam logic [3:0] KW_DEAD  = 4'd15;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_input;
  } src_word_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic [5:0]  token_length;
    logic [7:0]  token_char;
    logic        last;
  } tok_t;

  // up to two tokens handed from the scanner to the output queue
  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [3:0] kw_advance(input logic [3:0] p, input logic [7:0] c);
    logic [3:0] r;
    r = KW_DEAD;
    unique case (p)
      KW_START: begin
        if (c == "i") r = KW_I;
        else if (c == "w") r = KW_W;
      end
      KW_I:     if (c == "f") r = KW_IF;
      KW_W:     if (c == "h") r = KW_WH;
      KW_WH:    if (c == "i") r = KW_WHI;
      KW_WHI:   if (c == "l") r = KW_WHIL;
      KW_WHIL:  if (c == "e") r = KW_WHILE;
      default:  r = KW_DEAD;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/source_char_tokenizer.sv =====
`default_nettype none

// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+---------------------------------
// src      | in        | src_valid / src_ready  | src_data  : character, end_of_input
// tok      | out       | tok_valid / tok_ready  | tok_data  : one token per transfer
//
// one source word per cycle while src_ready is high; scanner state updates in the
// accept cycle and the resulting tokens (zero, one or two) land in a four-entry
// token queue; src_ready is high while the queue can take a full pair (fill of
// two or less); a word that adds two tokens always follows one that adds at most
// one, so the fill never passes two and a ready consumer never stalls the source
// tokens are registered into the queue when their word is accepted and are offered on tok from there
// synchronous reset puts line and column at 1, no run pending, queue empty

module source_char_tokenizer
  import sct_pkg::*;
#(
  parameter int unsigned POSITION_BITS = PosBitsDefault
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      src_valid,
  output logic           src_ready,
  input  wire src_word_t src_data,
  output logic           tok_valid,
  input  wire logic      tok_ready,
  output tok_t           tok_data
);

  push_t push;
  logic  accept;

  // accepted word, decoded straight into the scanner
  assign accept = src_valid && src_ready;

  // run tracking, keyword match and position counters
  sct_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .data   (src_data),
    .push   (push)
  );

  // token queue decouples the pair-per-word burst from the consumer
  sct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (src_ready),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_data  (tok_data)
  );

endmodule

`default_nettype wire

// ===== src/sct_scan.sv =====
`default_nettype none

module sct_scan
  import sct_pkg::*;
#(
  parameter int unsigned POSITION_BITS = PosBitsDefault
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      accept,
  input  wire src_word_t data,
  output push_t          push
);

  localparam logic [POSITION_BITS-1:0] PosMax = '1;
  localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);

  logic [1:0]               run_kind, run_kind_next;
  logic [POSITION_BITS-1:0] line_count, line_count_next;
  logic [POSITION_BITS-1:0] column_count, column_count_next;
  logic [POSITION_BITS-1:0] run_start_column, run_start_column_next;
  logic [5:0]               run_length, run_length_next;
  logic [3:0]               keyword_progress, keyword_progress_next;

  logic flush_v, tail_v;
  tok_t flush_tok, tail_tok;
  logic [7:0] c;
  logic word_ch;
  logic [POSITION_BITS-1:0] col_inc, line_inc;

  assign c       = data.character;
  assign word_ch = is_alpha(c) || (c == "_");
  assign col_inc  = (column_count == PosMax) ? column_count : column_count + PosOne;
  assign line_inc = (line_count == PosMax) ? line_count : line_count + PosOne;

  always_comb begin
    run_kind_next         = run_kind;
    line_count_next       = line_count;
    column_count_next     = column_count;
    run_start_column_next = run_start_column;
    run_length_next       = run_length;
    keyword_progress_next = keyword_progress;

    // pending run token, if the current character closes it
    flush_v                 = 1'b0;
    flush_tok.token_kind    = TOK_IDENT;
    if (run_kind == RUN_NUM) begin
      flush_tok.token_kind = TOK_NUMBER;
    end else if ((keyword_progress == KW_IF) || (keyword_progress == KW_WHILE)) begin
      flush_tok.token_kind = TOK_KEYWORD;
    end
    flush_tok.line_number   = 16'(line_count);
    flush_tok.column_number = 16'(run_start_column);
    flush_tok.token_length  = run_length;
    flush_tok.token_char    = 8'd0;
    flush_tok.last          = 1'b0;

    tail_v                 = 1'b0;
    tail_tok.token_kind    = TOK_ERROR;
    tail_tok.line_number   = 16'(line_count);
    tail_tok.column_number = 16'(column_count);
    tail_tok.token_length  = 6'd1;
    tail_tok.token_char    = c;
    tail_tok.last          = 1'b0;

    if (accept) begin
      if (data.end_of_input) begin
        flush_v                = (run_kind != RUN_NONE);
        tail_v                 = 1'b1;
        tail_tok.token_kind    = TOK_EOF;
        tail_tok.token_length  = 6'd0;
        tail_tok.token_char    = 8'd0;
        tail_tok.last          = 1'b1;
        run_kind_next          = RUN_NONE;
        line_count_next        = PosOne;
        column_count_next      = PosOne;
        run_start_column_next  = PosOne;
        run_length_next        = 6'd0;
        keyword_progress_next  = KW_START;
      end else if (((run_kind == RUN_WORD) && (word_ch || is_digit(c))) ||
                   ((run_kind == RUN_NUM) && is_digit(c))) begin
        if (run_length < 6'(LenCap)) run_length_next = run_length + 6'd1;
        keyword_progress_next = kw_advance(keyword_progress, c);
        column_count_next     = col_inc;
      end else begin
        flush_v = (run_kind != RUN_NONE);
        run_kind_next         = RUN_NONE;
        run_length_next       = 6'd0;
        keyword_progress_next = KW_START;
        if (c == 8'h0a) begin
          line_count_next   = line_inc;
          column_count_next = PosOne;
        end else if (is_space(c)) begin
          column_count_next = col_inc;
        end else if (word_ch || is_digit(c)) begin
          run_kind_next         = word_ch ? RUN_WORD : RUN_NUM;
          run_start_column_next = column_count;
          run_length_next       = 6'd1;
          keyword_progress_next = word_ch ? kw_advance(KW_START, c) : KW_DEAD;
          column_count_next     = col_inc;
        end else begin
          tail_v = 1'b1;
          if ((c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "=")) begin
            tail_tok.token_kind = TOK_OP;
          end else if (c == "(") begin
            tail_tok.token_kind = TOK_LPAREN;
          end else if (c == ")") begin
            tail_tok.token_kind = TOK_RPAREN;
          end
          column_count_next = col_inc;
        end
      end
    end

    push.count  = {1'b0, flush_v} + {1'b0, tail_v};
    push.first  = flush_v ? flush_tok : tail_tok;
    push.second = tail_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_kind         <= RUN_NONE;
      line_count       <= PosOne;
      column_count     <= PosOne;
      run_start_column <= PosOne;
      run_length       <= 6'd0;
      keyword_progress <= KW_START;
    end else begin
      run_kind         <= run_kind_next;
      line_count       <= line_count_next;
      column_count     <= column_count_next;
      run_start_column <= run_start_column_next;
      run_length       <= run_length_next;
      keyword_progress <= keyword_progress_next;
    end
  end

  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && data.end_of_input) |=>
      (run_kind == RUN_NONE) && (line_count == PosOne) && (column_count == PosOne))
    else $error("position not restarted after end of input");

  a_idle_len: assert property (@(posedge clk) disable iff (rst)
    (run_kind == RUN_NONE) |-> (run_length == 6'd0))
    else $error("run length held with no run pending");

  a_num_no_kw: assert property (@(posedge clk) disable iff (rst)
    (run_kind == RUN_NUM) |-> (keyword_progress == KW_DEAD))
    else $error("number run tracking a keyword");

endmodule

`default_nettype wire

// ===== src/sct_queue.sv =====
`default_nettype none

module sct_queue
  import sct_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  output logic       room,
  output logic       tok_valid,
  input  wire logic  tok_ready,
  output tok_t       tok_data
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tok_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count, count_next;
  logic            pop;

  assign pop       = tok_valid && tok_ready;
  assign tok_valid = (count != '0);
  assign tok_data  = mem[rd_ptr];
  // room for a full pair, whatever the consumer does this cycle
  assign room      = (count <= CntW'(Depth - 2));

  assign count_next = count + CntW'(push.count) - CntW'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.first;
    if (push.count == 2'd2) mem[wr_ptr + PtrW'(1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push.count);
      rd_ptr <= rd_ptr + PtrW'(pop);
      count  <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (count + CntW'(push.count) <= CntW'(Depth)))
    else $error("token queue overflow");

  a_empty_no_pop: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !tok_valid)
    else $error("token offered from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd0 && !pop) |=> $stable(count))
    else $error("queue fill changed with no push or pop");

endmodule

`default_nettype wire
